>>> rtl/amfm_gen_pkg.sv
package amfm_gen_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_FRAME_DEF = 65536;
  localparam int SINE_BITS_DEF = 10;

  // Configuration port
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int FRAME_W = 17;
  localparam int LEVEL_W = 20;
  localparam int NOISE_W = 16;
  localparam int STEP_W  = 31;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_MODE        = 3'd0;
  localparam logic [2:0] REG_CARRIER     = 3'd1;
  localparam logic [2:0] REG_MOD_STEP    = 3'd2;
  localparam logic [2:0] REG_MOD_LEVEL   = 3'd3;
  localparam logic [2:0] REG_NOISE_LEVEL = 3'd4;
  localparam logic [2:0] REG_FRAME_LEN   = 3'd5;

  localparam logic [FRAME_W-1:0] FRAME_LEN_RST = 17'd1024;

  // Odd polynomial for sin(pi/2 * x), x in Q30
  localparam longint K1 = 64'sd1686629713;
  localparam longint K3 = -64'sd693598671;
  localparam longint K5 = 64'sd85569304;
  localparam longint K7 = -64'sd5026995;
  localparam longint K9 = 64'sd172271;

  // Quarter-wave entry in Q1.15, range 0..32768; evaluated at elaboration only
  function automatic logic [15:0] sine_entry(input int idx, input int bits);
    longint x;
    longint x2;
    longint p;
    longint v;
    x  = longint'(idx) <<< (30 - bits);
    x2 = (x * x) >>> 30;
    p  = K9;
    p  = K7 + ((p * x2) >>> 30);
    p  = K5 + ((p * x2) >>> 30);
    p  = K3 + ((p * x2) >>> 30);
    p  = K1 + ((p * x2) >>> 30);
    p  = (p * x) >>> 30;
    v  = (p + (longint'(1) <<< 14)) >>> 15;
    if (v < 0) v = 0;
    if (v > 32768) v = 32768;
    return 16'(v);
  endfunction

endpackage

>>> rtl/am_fm_test_signal_generator_core.sv
// AM/FM test signal generator, one shared 21x17 multiplier and one sine ROM port.
// Each accepted item steps through S_MUL_M, S_CAR, S_MUL_C, S_NOISE and S_DONE; a new item
// is taken only back in S_IDLE. AM mode makes three passes through the multiplier, FM two,
// and both make two sine lookups; the last step holds until the output register is free.
// Reset: asynchronous, active low; phases and sample index clear, frame length 1024.
module am_fm_test_signal_generator_core
  import amfm_gen_pkg::*;
#(
  parameter int MAX_FRAME       = MAX_FRAME_DEF,
  parameter int SINE_TABLE_BITS = SINE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  // input items
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [15:0]              noise_draw_i,
  // result items
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [15:0]       sample_o,
  output logic                     frame_end_o
);

  localparam int QTR   = 1 << SINE_TABLE_BITS;
  localparam int IDX_W = (MAX_FRAME > 2) ? $clog2(MAX_FRAME) : 1;
  localparam int RA_W  = SINE_TABLE_BITS + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_M,
    S_CAR,
    S_MUL_C,
    S_NOISE,
    S_DONE
  } state_e;

  // ---------------- configuration registers ----------------
  logic               mode_q;
  logic [STEP_W-1:0]  carrier_step_q;
  logic [STEP_W-1:0]  mod_step_q;
  logic [LEVEL_W-1:0] mod_level_q;
  logic [NOISE_W-1:0] noise_level_q;
  logic [FRAME_W-1:0] frame_length_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= 1'b0;
      carrier_step_q <= '0;
      mod_step_q     <= '0;
      mod_level_q    <= '0;
      noise_level_q  <= '0;
      frame_length_q <= FRAME_LEN_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_MODE:        mode_q         <= pwdata[0];
        REG_CARRIER:     carrier_step_q <= pwdata[STEP_W-1:0];
        REG_MOD_STEP:    mod_step_q     <= pwdata[STEP_W-1:0];
        REG_MOD_LEVEL:   mod_level_q    <= pwdata[LEVEL_W-1:0];
        REG_NOISE_LEVEL: noise_level_q  <= pwdata[NOISE_W-1:0];
        REG_FRAME_LEN:   frame_length_q <= pwdata[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_MODE:        prdata = {31'd0, mode_q};
      REG_CARRIER:     prdata = {1'b0, carrier_step_q};
      REG_MOD_STEP:    prdata = {1'b0, mod_step_q};
      REG_MOD_LEVEL:   prdata = {12'd0, mod_level_q};
      REG_NOISE_LEVEL: prdata = {16'd0, noise_level_q};
      REG_FRAME_LEN:   prdata = {15'd0, frame_length_q};
      default:         prdata = '0;
    endcase
  end

  // ---------------- sine ROM, registered read ----------------
  logic [15:0] sine_rom [QTR+1];

  for (genvar g = 0; g <= QTR; g++) begin : g_rom
    assign sine_rom[g] = sine_entry(g, SINE_TABLE_BITS);
  end

  logic [31:0]          lut_phase;
  logic [RA_W-1:0]      rom_addr;
  logic [15:0]          rom_mag_q;
  logic                 rom_neg_q;
  logic signed [16:0]   sin_val;

  always_comb begin
    if (lut_phase[30]) begin
      rom_addr = RA_W'(QTR) - {1'b0, lut_phase[29 -: SINE_TABLE_BITS]};
    end else begin
      rom_addr = {1'b0, lut_phase[29 -: SINE_TABLE_BITS]};
    end
  end

  always_ff @(posedge clk_i) begin
    rom_mag_q <= sine_rom[rom_addr];
    rom_neg_q <= lut_phase[31];
  end

  assign sin_val = rom_neg_q ? -$signed({1'b0, rom_mag_q}) : $signed({1'b0, rom_mag_q});

  // ---------------- datapath ----------------
  state_e                state_q;
  logic [31:0]           carrier_phase_q;
  logic [31:0]           mod_phase_q;
  logic [IDX_W-1:0]      index_q;
  logic [15:0]           draw_q;
  logic signed [37:0]    mul_q;
  logic signed [20:0]    gain_q;
  logic signed [17:0]    sig_q;
  logic                  out_valid_q;
  logic signed [15:0]    sample_q;
  logic                  frame_end_q;

  logic signed [20:0]    mul_a;
  logic signed [16:0]    mul_b;
  logic signed [37:0]    prod;
  logic signed [18:0]    total;
  logic signed [15:0]    sat;
  logic [FRAME_W-1:0]    len_m1;
  logic                  last;
  logic                  out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign frame_end_o = frame_end_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    case (state_q)
      S_CAR:   lut_phase = mode_q ? carrier_phase_q
                                  : carrier_phase_q + {mul_q[30:0], 1'b0};
      default: lut_phase = mod_phase_q;
    endcase
  end

  always_comb begin
    case (state_q)
      S_MUL_C: begin
        mul_a = gain_q;
        mul_b = sin_val;
      end
      S_NOISE: begin
        mul_a = $signed({5'd0, noise_level_q});
        mul_b = $signed({~draw_q[15], ~draw_q[15], draw_q[14:0]});
      end
      default: begin
        mul_a = $signed({1'b0, mod_level_q});
        mul_b = sin_val;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // noise term is mul_q >>> 16 after the noise pass
  assign total = {sig_q[17], sig_q} + {{2{mul_q[32]}}, mul_q[32:16]};

  always_comb begin
    if (total > 19'sd32767) begin
      sat = 16'sd32767;
    end else if (total < -19'sd32768) begin
      sat = -16'sd32768;
    end else begin
      sat = total[15:0];
    end
  end

  always_comb begin
    if (frame_length_q == '0) begin
      len_m1 = '0;
    end else if (frame_length_q > FRAME_W'(MAX_FRAME)) begin
      len_m1 = FRAME_W'(MAX_FRAME - 1);
    end else begin
      len_m1 = frame_length_q - 1'b1;
    end
  end

  assign last = (FRAME_W'(index_q) >= len_m1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      carrier_phase_q <= '0;
      mod_phase_q     <= '0;
      index_q         <= '0;
      draw_q          <= '0;
      mul_q           <= '0;
      gain_q          <= '0;
      sig_q           <= '0;
      out_valid_q     <= 1'b0;
      sample_q        <= '0;
      frame_end_q     <= 1'b0;
    end else begin
      // in S_DONE the output register is handled below
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          // modulator lookup runs while idle, so sin_m is ready next cycle
          if (in_valid_i) begin
            draw_q  <= noise_draw_i;
            state_q <= S_MUL_M;
          end
        end
        S_MUL_M: begin
          mul_q   <= prod;
          state_q <= S_CAR;
        end
        S_CAR: begin
          gain_q  <= 21'sd32768 + mul_q[36:16];
          state_q <= S_MUL_C;
        end
        S_MUL_C: begin
          if (mode_q) begin
            mul_q <= prod;
          end else begin
            sig_q <= 18'(sin_val >>> 3);
          end
          state_q <= S_NOISE;
        end
        S_NOISE: begin
          if (mode_q) begin
            sig_q <= mul_q[35:18];
          end
          mul_q   <= prod;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            sample_q    <= sat;
            frame_end_q <= last;
            if (last) begin
              index_q         <= '0;
              carrier_phase_q <= '0;
              mod_phase_q     <= '0;
            end else begin
              index_q         <= index_q + 1'b1;
              carrier_phase_q <= carrier_phase_q + {1'b0, carrier_step_q};
              mod_phase_q     <= mod_phase_q + {1'b0, mod_step_q};
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
